### src/fcalc_pkg.sv
package fcalc_pkg;

    localparam int FUNC_W    = 3;
    localparam int DIGIT_W   = 4;
    localparam int OP_W      = 3;
    localparam int DISP_W    = 32;
    localparam int DigitBase = 10;
    localparam int DigitMax  = 9;

    typedef enum logic [FUNC_W-1:0] {
        F_DIGIT    = 3'd0,
        F_OPERATOR = 3'd1,
        F_EQUALS   = 3'd2,
        F_CLEAR    = 3'd3,
        F_CLEAR_E  = 3'd4,
        F_DELETE   = 3'd5,
        F_NEGATE   = 3'd6
    } t_func;

    typedef enum logic [OP_W-1:0] {
        OP_NONE = 3'd0,
        OP_ADD  = 3'd1,
        OP_SUB  = 3'd2,
        OP_MUL  = 3'd3,
        OP_DIV  = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_FIN,
        S_OUT
    } t_state;

endpackage

### src/fcalc_key_if.sv
interface fcalc_key_if
    import fcalc_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [FUNC_W-1:0]  func;
    logic [DIGIT_W-1:0] digit;
    logic [OP_W-1:0]    op_code;

    modport source (output valid, output func, output digit, output op_code, input ready);
    modport sink   (input valid, input func, input digit, input op_code, output ready);
endinterface

### src/fcalc_result_if.sv
interface fcalc_result_if
    import fcalc_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [DISP_W-1:0] display_value;
    logic                     div_zero;

    modport source (output valid, output display_value, output div_zero, input ready);
    modport sink   (input valid, input display_value, input div_zero, output ready);
endinterface

### src/four_function_keypad_calculator_core.sv
// Four-function keypad calculator, immediate execution.
// i_key carries one key press per transaction (func, digit, op_code);
// o_result returns exactly one transaction per key: the display value,
// sign-extended (or truncated) from VALUE_WIDTH to 32 bits, and a division-by-zero flag.
// A key is taken only while the sequencer is idle. Add, subtract, clear,
// clear-entry, negate, ignored keys and operator or equals keys that start
// no multiply or divide pass through S_OUT into the output register, and
// wait in S_OUT while it is still full; the sequencer then returns to idle.
// Multiply, divide, digit entry (entry * 10 + digit) and delete (display / 10)
// run on one shared shift-add / restoring-divide unit that retires one bit
// per cycle in S_MUL or S_DIV, then passes through S_FIN and S_OUT to the
// output register before the sequencer returns to idle for the next key.
// That bit loop sets the throughput.
// The result sits in an output register; the next key may be accepted while
// it waits there. If the receiver stalls, a finished second result holds in
// the sequencer until the output register empties.
// Reset (synchronous, active low) clears display, entry, accumulator,
// pending operator and the sequencing flags, and empties the output.
module four_function_keypad_calculator_core
    import fcalc_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    fcalc_key_if.sink      i_key,
    fcalc_result_if.source o_result
);
    localparam int W     = VALUE_WIDTH;
    localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

    t_state           r_state, n_state;
    logic [W-1:0]     r_disp, n_disp;
    logic [W-1:0]     r_entry, n_entry;
    logic [W-1:0]     r_acc, n_acc;
    t_op              r_pend, n_pend;
    logic             r_started, n_started;
    logic             r_new, n_new;
    logic             r_locked, n_locked;
    logic             r_dz, n_dz;
    logic             r_to_acc, n_to_acc;
    logic             r_negq, n_negq;
    logic [W-1:0]     r_a, n_a;
    logic [W-1:0]     r_b, n_b;
    logic [W-1:0]     r_rem, n_rem;
    logic [W-1:0]     r_prod, n_prod;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_oval, n_oval;
    logic [DISP_W-1:0] r_odisp, n_odisp;
    logic             r_odz, n_odz;

    logic             l_mul, l_div;
    logic [W-1:0]     l_a, l_b, l_init;
    logic [W-1:0]     ld_e, neg_e, res;
    logic [W:0]       trial;
    logic [DISP_W-1:0] disp_ext;
    t_func            key_func;
    t_op              key_op;
    logic             key_op_ok;

    generate
        if (W >= DISP_W) begin : g_trunc
            assign disp_ext = r_disp[DISP_W-1:0];
        end else begin : g_ext
            assign disp_ext = {{(DISP_W-W){r_disp[W-1]}}, r_disp};
        end
    endgenerate

    assign key_func  = t_func'(i_key.func);
    assign key_op    = t_op'(i_key.op_code);
    assign key_op_ok = (key_op == OP_ADD) || (key_op == OP_SUB)
                    || (key_op == OP_MUL) || (key_op == OP_DIV);

    assign i_key.ready            = (r_state == S_IDLE);
    assign o_result.valid         = r_oval;
    assign o_result.display_value = r_odisp;
    assign o_result.div_zero      = r_odz;

    assign ld_e  = r_new ? '0 : r_disp;
    assign neg_e = '0 - ld_e;
    assign trial = {r_rem, r_a[W-1]} - {1'b0, r_b};
    assign res   = r_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_disp    <= '0;
            r_entry   <= '0;
            r_acc     <= '0;
            r_pend    <= OP_NONE;
            r_started <= 1'b0;
            r_new     <= 1'b0;
            r_locked  <= 1'b0;
            r_oval    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_disp    <= n_disp;
            r_entry   <= n_entry;
            r_acc     <= n_acc;
            r_pend    <= n_pend;
            r_started <= n_started;
            r_new     <= n_new;
            r_locked  <= n_locked;
            r_oval    <= n_oval;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dz     <= n_dz;
        r_to_acc <= n_to_acc;
        r_negq   <= n_negq;
        r_a      <= n_a;
        r_b      <= n_b;
        r_rem    <= n_rem;
        r_prod   <= n_prod;
        r_cnt    <= n_cnt;
        r_odisp  <= n_odisp;
        r_odz    <= n_odz;
    end

    always_comb begin
        n_state   = r_state;
        n_disp    = r_disp;
        n_entry   = r_entry;
        n_acc     = r_acc;
        n_pend    = r_pend;
        n_started = r_started;
        n_new     = r_new;
        n_locked  = r_locked;
        n_dz      = r_dz;
        n_to_acc  = r_to_acc;
        n_negq    = r_negq;
        n_a       = r_a;
        n_b       = r_b;
        n_rem     = r_rem;
        n_prod    = r_prod;
        n_cnt     = r_cnt;
        n_oval    = r_oval && !o_result.ready;
        n_odisp   = r_odisp;
        n_odz     = r_odz;
        l_mul     = 1'b0;
        l_div     = 1'b0;
        l_a       = r_acc;
        l_b       = r_entry;
        l_init    = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_key.valid) begin
                    n_dz    = 1'b0;
                    n_state = S_OUT;
                    case (key_func)
                        F_DIGIT: begin
                            if (i_key.digit <= DIGIT_W'(DigitMax)) begin
                                if (r_new) n_acc = r_disp;
                                n_new    = 1'b0;
                                n_locked = 1'b0;
                                l_mul    = 1'b1;
                                l_a      = ld_e;
                                l_b      = W'(DigitBase);
                                l_init   = {{(W-DIGIT_W){1'b0}}, i_key.digit};
                                n_to_acc = 1'b0;
                            end
                        end
                        F_OPERATOR, F_EQUALS: begin
                            if (key_func == F_EQUALS || key_op_ok) begin
                                if (key_func == F_OPERATOR &&
                                    (!r_started || r_locked)) begin
                                    n_pend = key_op;
                                end else begin
                                    // run the pending operation
                                    n_to_acc = 1'b1;
                                    case (r_pend)
                                        OP_ADD: begin
                                            n_acc  = r_acc + r_entry;
                                            n_disp = r_acc + r_entry;
                                        end
                                        OP_SUB: begin
                                            n_acc  = r_acc - r_entry;
                                            n_disp = r_acc - r_entry;
                                        end
                                        OP_MUL: l_mul = 1'b1;
                                        OP_DIV: begin
                                            if (r_entry == '0) begin
                                                n_dz   = 1'b1;
                                                n_disp = r_acc;
                                            end else begin
                                                l_div = 1'b1;
                                            end
                                        end
                                        default: n_disp = r_acc;
                                    endcase
                                    n_locked = 1'b1;
                                    if (key_func == F_OPERATOR && r_pend != OP_NONE)
                                        n_pend = key_op;
                                end
                                n_new     = 1'b1;
                                n_started = (key_func == F_OPERATOR);
                            end
                        end
                        F_CLEAR: begin
                            n_disp    = '0;
                            n_entry   = '0;
                            n_acc     = '0;
                            n_pend    = OP_NONE;
                            n_started = 1'b0;
                            n_new     = 1'b0;
                            n_locked  = 1'b0;
                        end
                        F_CLEAR_E: begin
                            n_entry = '0;
                            n_disp  = '0;
                        end
                        F_DELETE: begin
                            l_div    = 1'b1;
                            l_a      = r_disp;
                            l_b      = W'(DigitBase);
                            n_to_acc = 1'b0;
                        end
                        F_NEGATE: begin
                            if (r_new) n_acc = r_disp;
                            n_new    = 1'b0;
                            n_locked = 1'b0;
                            n_entry  = neg_e;
                            n_disp   = neg_e;
                        end
                        default: ;
                    endcase

                    n_cnt = CNT_W'(VALUE_WIDTH);
                    if (l_mul) begin
                        n_a     = l_a;
                        n_b     = l_b;
                        n_prod  = l_init;
                        n_state = S_MUL;
                    end else if (l_div) begin
                        n_negq  = l_a[W-1] ^ l_b[W-1];
                        n_a     = l_a[W-1] ? '0 - l_a : l_a;
                        n_b     = l_b[W-1] ? '0 - l_b : l_b;
                        n_rem   = '0;
                        n_state = S_DIV;
                    end
                end
            end
            S_MUL: begin
                if (r_b[0]) n_prod = r_prod + r_a;
                n_a   = {r_a[W-2:0], 1'b0};
                n_b   = {1'b0, r_b[W-1:1]};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) n_state = S_FIN;
            end
            S_DIV: begin
                // restoring step: quotient bits shift into r_a
                if (!trial[W]) begin
                    n_rem = trial[W-1:0];
                    n_a   = {r_a[W-2:0], 1'b1};
                end else begin
                    n_rem = {r_rem[W-2:0], r_a[W-1]};
                    n_a   = {r_a[W-2:0], 1'b0};
                end
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    n_prod  = r_negq ? '0 - n_a : n_a;
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (r_to_acc) n_acc = res;
                else          n_entry = res;
                n_disp  = res;
                n_state = S_OUT;
            end
            S_OUT: begin
                // hold until the output register is free
                if (!r_oval || o_result.ready) begin
                    n_oval  = 1'b1;
                    n_odisp = disp_ext;
                    n_odz   = r_dz;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

### sim/four_function_keypad_calculator_core_test.sv
module four_function_keypad_calculator_core_test;
    import fcalc_pkg::*;

    localparam logic [FUNC_W-1:0] F_UNUSED    = 3'd7;
    localparam logic [OP_W-1:0]   OP_CODE_TOP = 3'd7;
    localparam logic [31:0]       MIN_VAL     = 32'h8000_0000;
    localparam int RANDOM_KEYS  = 1330;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 48;
    localparam int LOG_LIMIT    = 40;

    typedef struct packed {
        logic [31:0] value;
        logic        dz;
    } t_calc_out;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [DIGIT_W-1:0] digit;
        logic [OP_W-1:0]    op;
        logic               typed;
        logic [31:0]        value;
        logic               dz;
    } t_key_row;

    // Directed keys: walks add, subtract, a swapped operator, divide, multiply
    // by repeated equals up to the most negative value, then that value
    // divided by minus one, delete of a negative number and division by zero.
    localparam t_key_row KEY_SCRIPT [26] = '{
        '{F_DIGIT,    4'd9,  OP_NONE,     1'b1, 32'd9,   1'b0},
        '{F_DIGIT,    4'd15, OP_ADD,      1'b1, 32'd9,   1'b0},
        '{F_OPERATOR, 4'd0,  OP_ADD,      1'b1, 32'd9,   1'b0},
        '{F_DIGIT,    4'd7,  OP_NONE,     1'b0, 32'd0,   1'b0},
        '{F_OPERATOR, 4'd0,  OP_SUB,      1'b1, 32'd16,  1'b0},
        '{F_OPERATOR, 4'd0,  OP_DIV,      1'b0, 32'd0,   1'b0},
        '{F_OPERATOR, 4'd0,  OP_CODE_TOP, 1'b0, 32'd0,   1'b0},
        '{F_UNUSED,   4'd3,  OP_MUL,      1'b1, 32'd16,  1'b0},
        '{F_DIGIT,    4'd8,  OP_NONE,     1'b0, 32'd0,   1'b0},
        '{F_OPERATOR, 4'd0,  OP_MUL,      1'b1, 32'd2,   1'b0},
        '{F_DIGIT,    4'd1,  OP_NONE,     1'b0, 32'd0,   1'b0},
        '{F_DIGIT,    4'd0,  OP_NONE,     1'b0, 32'd0,   1'b0},
        '{F_DIGIT,    4'd2,  OP_NONE,     1'b0, 32'd0,   1'b0},
        '{F_DIGIT,    4'd4,  OP_NONE,     1'b1, 32'd1024, 1'b0},
        '{F_EQUALS,   4'd0,  OP_NONE,     1'b0, 32'd0,   1'b0},
        '{F_EQUALS,   4'd0,  OP_NONE,     1'b0, 32'd0,   1'b0},
        '{F_EQUALS,   4'd0,  OP_NONE,     1'b1, MIN_VAL, 1'b0},
        '{F_OPERATOR, 4'd0,  OP_DIV,      1'b1, MIN_VAL, 1'b0},
        '{F_NEGATE,   4'd0,  OP_NONE,     1'b1, 32'd0,   1'b0},
        '{F_DIGIT,    4'd1,  OP_NONE,     1'b0, 32'd0,   1'b0},
        '{F_NEGATE,   4'd0,  OP_NONE,     1'b0, 32'd0,   1'b0},
        '{F_EQUALS,   4'd0,  OP_NONE,     1'b1, MIN_VAL, 1'b0},
        '{F_DELETE,   4'd0,  OP_NONE,     1'b0, 32'd0,   1'b0},
        '{F_CLEAR_E,  4'd0,  OP_NONE,     1'b1, 32'd0,   1'b0},
        '{F_EQUALS,   4'd0,  OP_NONE,     1'b1, MIN_VAL, 1'b1},
        '{F_CLEAR,    4'd0,  OP_NONE,     1'b1, 32'd0,   1'b0}
    };

    logic i_clk;
    logic i_rst_n;

    fcalc_key_if    key_if ();
    fcalc_result_if res_if ();

    four_function_keypad_calculator_core DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_key    (key_if),
        .o_result (res_if)
    );

    // calculator state as the keys should leave it
    logic [31:0] calc_disp;
    logic [31:0] calc_entry;
    logic [31:0] calc_acc;
    t_op         calc_pend;
    logic        calc_started;
    logic        calc_fresh;
    logic        calc_locked;

    t_calc_out due_displays [$];

    int  mismatches   = 0;
    int  keys_sent    = 0;
    int  results_seen = 0;
    int  dz_seen      = 0;
    int  idle_cycles  = 0;
    bit  tx_gaps_on   = 1'b1;
    bit  rx_stalls_on = 1'b1;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string msg);
        if (mismatches < LOG_LIMIT) begin
            $display("ERROR @%0t: %s", $realtime, msg);
        end
        mismatches++;
    endtask

    function automatic void clear_calc();
        calc_disp    = '0;
        calc_entry   = '0;
        calc_acc     = '0;
        calc_pend    = OP_NONE;
        calc_started = 1'b0;
        calc_fresh   = 1'b0;
        calc_locked  = 1'b0;
    endfunction

    // signed divide truncating toward zero, done on magnitudes so that
    // the most negative value over minus one wraps back to itself
    function automatic logic [31:0] trunc_div(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] mag_a;
        logic [31:0] mag_b;
        logic [31:0] q;
        mag_a = a[31] ? -a : a;
        mag_b = b[31] ? -b : b;
        q = mag_a / mag_b;
        return (a[31] != b[31]) ? -q : q;
    endfunction

    function automatic void load_entry();
        calc_entry = calc_disp;
        if (calc_fresh) begin
            calc_acc   = calc_entry;
            calc_entry = '0;
        end
        calc_fresh  = 1'b0;
        calc_locked = 1'b0;
    endfunction

    function automatic logic run_pending();
        case (calc_pend)
            OP_ADD: calc_acc = calc_acc + calc_entry;
            OP_SUB: calc_acc = calc_acc - calc_entry;
            OP_MUL: calc_acc = calc_acc * calc_entry;
            OP_DIV: begin
                if (calc_entry == '0) begin
                    return 1'b1;
                end
                calc_acc = trunc_div(calc_acc, calc_entry);
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    function automatic t_calc_out press_key(input logic [FUNC_W-1:0] f,
                                            input logic [DIGIT_W-1:0] d,
                                            input logic [OP_W-1:0] o);
        t_calc_out r;
        r.dz = 1'b0;
        case (f)
            F_DIGIT: begin
                if (d <= DigitMax) begin
                    load_entry();
                    calc_entry = calc_entry * DigitBase + 32'(d);
                    calc_disp  = calc_entry;
                end
            end
            F_OPERATOR: begin
                if (o >= OP_ADD && o <= OP_DIV) begin
                    if (!calc_started) begin
                        calc_pend = t_op'(o);
                    end else if (!calc_locked) begin
                        r.dz = run_pending();
                        if (calc_pend != OP_NONE) begin
                            calc_pend = t_op'(o);
                        end
                        calc_disp   = calc_acc;
                        calc_locked = 1'b1;
                    end else begin
                        calc_pend = t_op'(o);
                    end
                    calc_started = 1'b1;
                    calc_fresh   = 1'b1;
                end
            end
            F_EQUALS: begin
                r.dz         = run_pending();
                calc_disp    = calc_acc;
                calc_started = 1'b0;
                calc_fresh   = 1'b1;
                calc_locked  = 1'b1;
            end
            F_CLEAR: clear_calc();
            F_CLEAR_E: begin
                calc_entry = '0;
                calc_disp  = '0;
            end
            F_DELETE: begin
                calc_entry = trunc_div(calc_disp, DigitBase);
                calc_disp  = calc_entry;
            end
            F_NEGATE: begin
                load_entry();
                calc_entry = -calc_entry;
                calc_disp  = calc_entry;
            end
            default: ;
        endcase
        r.value = calc_disp;
        return r;
    endfunction

    // drive one key, hold it until taken, then queue what the display must show
    task automatic send_key(input logic [FUNC_W-1:0] f, input logic [DIGIT_W-1:0] d,
                            input logic [OP_W-1:0] o, input logic typed,
                            input logic [31:0] want, input logic want_dz);
        int        gap;
        t_calc_out due;
        gap = tx_gaps_on ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            key_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        key_if.valid   <= 1'b1;
        key_if.func    <= f;
        key_if.digit   <= d;
        key_if.op_code <= o;
        do @(posedge i_clk); while (!key_if.ready);
        due = press_key(f, d, o);
        if (typed) begin
            due.value = want;
            due.dz    = want_dz;
        end
        due_displays.push_back(due);
        keys_sent++;
    endtask

    // mostly keys that move the calculator along, with a little noise
    task automatic send_random_key();
        int                 roll;
        logic [FUNC_W-1:0]  f;
        logic [DIGIT_W-1:0] d;
        logic [OP_W-1:0]    o;
        roll = $urandom_range(0, 99);
        d = DIGIT_W'($urandom_range(0, 15));
        o = OP_W'($urandom_range(0, 7));
        if (roll < 48) begin
            f = F_DIGIT;
            d = DIGIT_W'($urandom_range(0, DigitMax));
        end else if (roll < 66) begin
            f = F_OPERATOR;
            o = OP_W'($urandom_range(OP_ADD, OP_DIV));
        end else if (roll < 76) begin
            f = F_EQUALS;
        end else if (roll < 79) begin
            f = F_CLEAR;
        end else if (roll < 83) begin
            f = F_CLEAR_E;
        end else if (roll < 88) begin
            f = F_DELETE;
        end else if (roll < 93) begin
            f = F_NEGATE;
        end else if (roll < 96) begin
            f = F_DIGIT;
            d = DIGIT_W'($urandom_range(DigitMax + 1, 15));
        end else if (roll < 98) begin
            f = F_OPERATOR;
            o = ($urandom_range(0, 3) == 0) ? OP_NONE
                                            : OP_W'($urandom_range(OP_DIV + 1, OP_CODE_TOP));
        end else begin
            f = F_UNUSED;
        end
        send_key(f, d, o, 1'b0, '0, 1'b0);
    endtask

    task automatic drain_displays();
        key_if.valid <= 1'b0;
        while (due_displays.size() != 0) @(posedge i_clk);
    endtask

    // result side: random stalls, check each transaction against the oldest due display
    initial begin
        int        stall;
        t_calc_out due;
        res_if.ready <= 1'b0;
        // hold off until reset is released and the output register is defined
        wait (i_rst_n === 1'b1);
        forever begin
            stall = rx_stalls_on ? $urandom_range(0, 3) : 0;
            if (stall > 0) begin
                res_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
            do @(posedge i_clk); while (!res_if.valid);
            results_seen++;
            if (res_if.div_zero) begin
                dz_seen++;
            end
            if (due_displays.size() == 0) begin
                report_mismatch($sformatf("result %0d with nothing due",
                                          $signed(res_if.display_value)));
            end else begin
                due = due_displays.pop_front();
                if (res_if.display_value !== due.value) begin
                    report_mismatch($sformatf("display_value got %0d want %0d",
                                              $signed(res_if.display_value),
                                              $signed(due.value)));
                end
                if (res_if.div_zero !== due.dz) begin
                    report_mismatch($sformatf("div_zero got %0b want %0b",
                                              res_if.div_zero, due.dz));
                end
            end
        end
    end

    // count cycles in which neither channel moves a transaction
    always @(posedge i_clk) begin
        if (!i_rst_n || (key_if.valid && key_if.ready) || (res_if.valid && res_if.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("ERROR: no transaction for %0d cycles", STALL_LIMIT);
                $display("four_function_keypad_calculator_core verification failed");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n        <= 1'b0;
        key_if.valid   <= 1'b0;
        key_if.func    <= F_DIGIT;
        key_if.digit   <= '0;
        key_if.op_code <= OP_NONE;
        clear_calc();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (KEY_SCRIPT[i]) begin
            send_key(KEY_SCRIPT[i].func, KEY_SCRIPT[i].digit, KEY_SCRIPT[i].op,
                     KEY_SCRIPT[i].typed, KEY_SCRIPT[i].value, KEY_SCRIPT[i].dz);
        end
        // hold the keypad until every directed display is back
        drain_displays();

        for (int n = 0; n < RANDOM_KEYS; n++) begin
            if (n % 150 == 0) begin
                tx_gaps_on   = ($urandom_range(0, 3) != 0);
                rx_stalls_on = ($urandom_range(0, 3) != 0);
            end
            // one long stretch at full rate on both sides
            if (n >= 400 && n < 550) begin
                tx_gaps_on   = 1'b0;
                rx_stalls_on = 1'b0;
            end
            if (n == 700) begin
                drain_displays();
            end
            send_random_key();
        end
        key_if.valid <= 1'b0;

        while (due_displays.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d directed and random key presses; %0d displays checked,",
                 keys_sent, results_seen);
        $display("%0d of them division by zero, %0d mismatches", dz_seen, mismatches);
        if (mismatches == 0 && due_displays.size() == 0) begin
            $display("four_function_keypad_calculator_core verification clean");
        end else begin
            $display("four_function_keypad_calculator_core verification failed");
        end
        $finish;
    end

endmodule
